FILE: rtl/local_alignment_stripe_scorer_defines.svh
// Assertion macros shared by the stripe scorer RTL.
`ifndef LOCAL_ALIGNMENT_STRIPE_SCORER_DEFINES_SVH
`define LOCAL_ALIGNMENT_STRIPE_SCORER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled in reset.
`define LASS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stripe scorer check failed");

// Next-cycle implication, disabled in reset.
`define LASS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stripe scorer check failed");

`else

`define LASS_ASSERT_NOW(label, clk, rst, ante, cons)
`define LASS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/lass_pkg.sv
// Types, constants and helpers for the local alignment stripe scorer.
package lass_pkg;

   // Default number of query rows in the stripe
   localparam int ROWS_DEFAULT = 16;

   // Rows covered by the query base register
   localparam int QUERY_REG_ROWS = 16;

   // Field widths
   localparam int SYM_W   = 16;
   localparam int TOP_W   = 16;
   localparam int SCORE_W = 15;
   localparam int QLEN_W  = 5;
   localparam int QBASE_W = 32;
   localparam int SUM_W   = 18;

   // Register indexes
   localparam logic REG_QUERY_BASES  = 1'b0;
   localparam logic REG_QUERY_LENGTH = 1'b1;

   // Register reset values
   localparam logic [QBASE_W-1:0] QUERY_BASES_RESET  = '0;
   localparam logic [QLEN_W-1:0]  QUERY_LENGTH_RESET = 5'd16;

   // Scoring constants
   localparam logic signed [SUM_W-1:0] MATCH_GAIN    = 18'sd2;
   localparam logic signed [SUM_W-1:0] MISMATCH_COST = -18'sd1;
   localparam logic signed [SUM_W-1:0] GAP_COST      = -18'sd1;
   localparam logic signed [SUM_W-1:0] SCORE_MAX     = 18'sd32767;
   localparam logic [SYM_W-1:0]        NO_BASE       = 16'd4;

   // Word moving from one cell to the next
   typedef struct packed {
      logic                     valid;
      logic signed [TOP_W-1:0]  above;
      logic                     is_base;
      logic [1:0]               sym;
      logic                     final_item;
      logic [SCORE_W-1:0]       best;
      logic [SCORE_W-1:0]       left;
      logic [3:0]               keep;
      logic [3:0]               strobe;
      logic                     user;
      logic                     ident;
      logic                     dest;
   } wave_type;

   // Result word
   typedef struct packed {
      logic [SCORE_W-1:0] bottom_score;
      logic               group_end;
      logic [SCORE_W-1:0] best_score;
      logic [3:0]         keep;
      logic [3:0]         strobe;
      logic               user;
      logic               ident;
      logic               dest;
   } result_type;

   // Query base of one row; rows past the register read base A
   function automatic logic [1:0] row_base(input logic [QBASE_W-1:0] bases, input int row);
      logic [1:0] base;
      base = 2'd0;
      if (row < QUERY_REG_ROWS) begin
         base = bases[2*row +: 2];
      end
      return base;
   endfunction

endpackage

FILE: rtl/local_alignment_stripe_scorer.sv
// Top level of the Smith-Waterman stripe scorer: registers, cell chain, output stage.
//
//  Channel  Ports                Direction  Contents
//  req      req_t*               in         one subject column per word
//  rsp      rsp_t*               out        one result per column, in order
//  csr      csr_wr_en/addr/wdata in         query_bases (0), query_length (1)
//
// Each column walks the chain of ROWS cells one row per cycle unless rsp stalls; the
// chain moves as a whole, so a new word enters every such cycle and a result leaves
// through the ROWS cell registers and then the result register. A stalled rsp side
// freezes every cell and drops req_tready in the same cycle. Reset clears all cell
// scores, the best score and the group counter at once and sets query_length to 16.
`include "local_alignment_stripe_scorer_defines.svh"

module local_alignment_stripe_scorer
   import lass_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // req: tdata = subject_symbol[15:0], top_score[31:16], in_keep[35:32],
   //      in_strobe[39:36], in_ident[40], in_dest[41], zero[47:42]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,
   input  logic         req_tlast,
   // req_tuser = in_user[0]
   input  logic         req_tuser,
   // rsp: tdata = bottom_score[14:0], best_score[29:15], out_keep[33:30],
   //      out_strobe[37:34], out_ident[38], out_dest[39]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,
   output logic         rsp_tlast,
   // rsp_tuser = out_user[0]
   output logic         rsp_tuser,
   // configuration writes
   input  logic         csr_wr_en,
   input  logic         csr_addr,
   input  logic [31:0]  csr_wdata
);

   logic [QBASE_W-1:0] query_bases_ff;
   logic [QLEN_W-1:0]  query_length_ff;
   logic               advance;
   wave_type           wave [ROWS+1];
   result_type         rsp_data;
   logic [SYM_W-1:0]   req_sym;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         query_bases_ff  <= QUERY_BASES_RESET;
         query_length_ff <= QUERY_LENGTH_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            REG_QUERY_BASES: begin
               query_bases_ff <= csr_wdata;
            end
            REG_QUERY_LENGTH: begin
               query_length_ff <= csr_wdata[QLEN_W-1:0];
            end
            default: begin
               query_bases_ff <= query_bases_ff;
            end
         endcase
      end
   end

   // Unpack the request word into the head of the chain
   assign req_sym = req_tdata[15:0];
   always_comb begin
      wave[0].valid      = req_tvalid;
      wave[0].above      = $signed(req_tdata[31:16]);
      wave[0].is_base    = (req_sym < NO_BASE);
      wave[0].sym        = req_sym[1:0];
      wave[0].final_item = req_tlast;
      wave[0].best       = '0;
      wave[0].left       = '0;
      wave[0].keep       = req_tdata[35:32];
      wave[0].strobe     = req_tdata[39:36];
      wave[0].user       = req_tuser;
      wave[0].ident      = req_tdata[40];
      wave[0].dest       = req_tdata[41];
   end

   assign req_tready = advance;

   // Row cells
   for (genvar r = 0; r < ROWS; r++) begin : g_row
      logic [1:0] query_base;
      logic       match_en;

      assign query_base = row_base(query_bases_ff, r);
      assign match_en   = ({1'b0, query_length_ff} > (QLEN_W+1)'(r));

      lass_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .query_base (query_base),
         .match_en   (match_en),
         .wave_in    (wave[r]),
         .wave_out   (wave[r+1])
      );
   end

   lass_out #(
      .ROWS (ROWS)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .wave_in   (wave[ROWS]),
      .rsp_ready (rsp_tready),
      .advance   (advance),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp_data)
   );

   // Pack the result word
   assign rsp_tdata = {rsp_data.dest, rsp_data.ident, rsp_data.strobe, rsp_data.keep,
                       rsp_data.best_score, rsp_data.bottom_score};
   assign rsp_tlast = rsp_data.group_end;
   assign rsp_tuser = rsp_data.user;

endmodule

FILE: rtl/lass_cell.sv
// One query row of the systolic stripe: scores its column and hands it down.
`include "local_alignment_stripe_scorer_defines.svh"

module lass_cell
   import lass_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [1:0] query_base,
   input  logic       match_en,
   input  wave_type   wave_in,
   output wave_type   wave_out
);

   logic signed [TOP_W-1:0]   diag_ff, diag_in;
   logic [SCORE_W-1:0]        left_ff, left_in;
   logic                      valid_ff;
   wave_type                  data_ff, data_in;

   logic signed [SUM_W-1:0]   above_ext;
   logic signed [SUM_W-1:0]   left_ext;
   logic signed [SUM_W-1:0]   diag_sum;
   logic signed [SUM_W-1:0]   gap_sum;
   logic signed [SUM_W-1:0]   peak;
   logic [SCORE_W-1:0]        h_score;
   logic                      take;

   assign take      = advance && wave_in.valid;
   assign above_ext = SUM_W'(wave_in.above);
   assign left_ext  = $signed({{(SUM_W-SCORE_W){1'b0}}, left_ff});

   // Score the cell: diagonal, gap, clamp at zero, saturate
   always_comb begin
      if (match_en && wave_in.is_base) begin
         diag_sum = SUM_W'(diag_ff) +
                    ((wave_in.sym == query_base) ? MATCH_GAIN : MISMATCH_COST);
      end else begin
         diag_sum = '0;
      end
      gap_sum = ((left_ext > above_ext) ? left_ext : above_ext) + GAP_COST;
      peak    = (diag_sum > gap_sum) ? diag_sum : gap_sum;
      if (peak < 0) begin
         h_score = '0;
      end else if (peak > SCORE_MAX) begin
         h_score = SCORE_W'(SCORE_MAX);
      end else begin
         h_score = peak[SCORE_W-1:0];
      end
   end

   // Next row state; a final word clears the row
   always_comb begin
      diag_in = diag_ff;
      left_in = left_ff;
      if (take) begin
         if (wave_in.final_item) begin
            diag_in = '0;
            left_in = '0;
         end else begin
            diag_in = wave_in.above;
            if (wave_in.is_base) begin
               left_in = h_score;
            end
         end
      end
   end

   // Word for the next row
   always_comb begin
      data_in       = wave_in;
      data_in.above = $signed({1'b0, h_score});
      data_in.best  = (h_score > wave_in.best) ? h_score : wave_in.best;
      data_in.left  = wave_in.is_base ? h_score : left_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diag_ff  <= '0;
         left_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         diag_ff <= diag_in;
         left_ff <= left_in;
         if (advance) begin
            valid_ff <= wave_in.valid;
         end
      end
   end

   // Hold payload unless the chain moves
   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      wave_out       = data_ff;
      wave_out.valid = valid_ff;
   end

   `LASS_ASSERT_NEXT(a_final_clears_row, clock, reset,
      take && wave_in.final_item, diag_ff == '0 && left_ff == '0)
   `LASS_ASSERT_NEXT(a_no_base_keeps_left, clock, reset,
      take && !wave_in.is_base && !wave_in.final_item, $stable(left_ff))
   `LASS_ASSERT_NOW(a_best_covers_cell, clock, reset,
      valid_ff, data_ff.best >= data_ff.above[SCORE_W-1:0])

endmodule

FILE: rtl/lass_out.sv
// Output stage: running best, group counter and result register.
`include "local_alignment_stripe_scorer_defines.svh"

module lass_out
   import lass_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  wave_type   wave_in,
   input  logic       rsp_ready,
   output logic       advance,
   output logic       rsp_valid,
   output result_type rsp_data
);

   localparam int CNT_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROWS - 1);

   logic [SCORE_W-1:0] best_ff, best_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               valid_ff;
   result_type         data_ff, data_in;
   logic [SCORE_W-1:0] best_now;
   logic               wrap;
   logic               take;

   // The whole chain moves when the result register is empty or its result is taken
   assign advance = !valid_ff || rsp_ready;
   assign take    = advance && wave_in.valid;

   assign best_now = (wave_in.best > best_ff) ? wave_in.best : best_ff;
   assign wrap     = (cnt_ff >= CNT_LAST);

   // Advance best and counter; clear them after a final word
   always_comb begin
      best_in = best_ff;
      cnt_in  = cnt_ff;
      if (take) begin
         if (wave_in.final_item) begin
            best_in = '0;
            cnt_in  = '0;
         end else begin
            best_in = best_now;
            cnt_in  = wrap ? '0 : cnt_ff + CNT_W'(1);
         end
      end
   end

   // Build the result word
   always_comb begin
      data_in.bottom_score = wave_in.left;
      data_in.group_end    = wrap || wave_in.final_item;
      data_in.best_score   = best_now;
      data_in.keep         = wave_in.keep;
      data_in.strobe       = wave_in.strobe;
      data_in.user         = wave_in.user;
      data_in.ident        = wave_in.ident;
      data_in.dest         = wave_in.dest;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff  <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         best_ff <= best_in;
         cnt_ff  <= cnt_in;
         if (advance) begin
            valid_ff <= wave_in.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   `LASS_ASSERT_NEXT(a_final_clears_best, clock, reset,
      take && wave_in.final_item, best_ff == '0 && cnt_ff == '0)
   `LASS_ASSERT_NEXT(a_best_monotonic, clock, reset,
      take && !wave_in.final_item, best_ff >= $past(best_ff))
   `LASS_ASSERT_NOW(a_best_covers_bottom, clock, reset,
      valid_ff, data_ff.best_score >= data_ff.bottom_score)

endmodule

FILE: test/stripe_scorer_checker.sv
// Scoreboard for the stripe scorer: column predictor and in-order result compare.
module stripe_scorer_checker
   import lass_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tlast,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,
   input  logic        csr_wr_en,
   input  logic        csr_addr,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          open_count,
   output int          checked_count
);

   localparam int MATCH_BONUS      = 2;
   localparam int MISMATCH_PENALTY = -1;
   localparam int GAP_PENALTY      = -1;
   localparam int SCORE_CEIL       = 32767;
   localparam int REPORT_LIMIT     = 10;

   // Shadow copy of the query registers
   logic [QBASE_W-1:0] bases_q;
   logic [QLEN_W-1:0]  qlen_q;

   // Shadow copy of the column state
   logic [SCORE_W-1:0]      left_q [ROWS];
   logic signed [TOP_W-1:0] diag_q [ROWS];
   logic [SCORE_W-1:0]      best_q;
   int                      group_q;

   result_type awaited_results [$];
   int errors  = 0;
   int matched = 0;

   // Drop all alignment state; the registers stay
   function automatic void clear_columns();
      for (int r = 0; r < ROWS; r++) begin
         left_q[r] = '0;
         diag_q[r] = '0;
      end
      best_q  = '0;
      group_q = 0;
   endfunction

   // Run one subject column down the stripe and build its result word
   function automatic result_type score_column(input logic [47:0] word, input logic last,
                                               input logic user);
      logic [SYM_W-1:0] sym;
      logic             is_base;
      logic [1:0]       qbase;
      int               above;
      int               diag;
      int               gap;
      int               lft;
      int               h;
      result_type       res;
      sym     = word[15:0];
      above   = int'($signed(word[31:16]));
      is_base = (sym < NO_BASE);
      for (int r = 0; r < ROWS; r++) begin
         qbase = (r < QUERY_REG_ROWS) ? bases_q[2*r +: 2] : 2'd0;
         diag  = 0;
         if (r < qlen_q && is_base) begin
            diag = int'(diag_q[r]) + ((sym[1:0] == qbase) ? MATCH_BONUS : MISMATCH_PENALTY);
         end
         lft = int'(left_q[r]);
         gap = ((lft > above) ? lft : above) + GAP_PENALTY;
         h = 0;
         if (diag > h) h = diag;
         if (gap > h) h = gap;
         if (h > SCORE_CEIL) h = SCORE_CEIL;
         diag_q[r] = above[TOP_W-1:0];
         if (is_base) left_q[r] = h[SCORE_W-1:0];
         if (h > int'(best_q)) best_q = h[SCORE_W-1:0];
         above = h;
      end
      res.group_end    = (group_q == ROWS - 1) || last;
      group_q          = (group_q == ROWS - 1) ? 0 : group_q + 1;
      res.bottom_score = left_q[ROWS-1];
      res.best_score   = best_q;
      res.keep         = word[35:32];
      res.strobe       = word[39:36];
      res.user         = user;
      res.ident        = word[40];
      res.dest         = word[41];
      if (last) clear_columns();
      return res;
   endfunction

   // Count a failure and show the first few
   function automatic void note_failure(input logic orphan, input result_type want,
                                        input result_type seen);
      errors++;
      if (errors <= REPORT_LIMIT) begin
         if (orphan) begin
            $display("checker: result word with none awaited: bottom %0d last %0b best %0d",
                     seen.bottom_score, seen.group_end, seen.best_score);
         end else begin
            $display("checker: mismatch on result %0d", matched);
            $display("  expected bottom %0d last %0b best %0d keep %h strb %h user %b id %b dest %b",
                     want.bottom_score, want.group_end, want.best_score, want.keep,
                     want.strobe, want.user, want.ident, want.dest);
            $display("  actual   bottom %0d last %0b best %0d keep %h strb %h user %b id %b dest %b",
                     seen.bottom_score, seen.group_end, seen.best_score, seen.keep,
                     seen.strobe, seen.user, seen.ident, seen.dest);
         end
      end
   endfunction

   // Track registers, predict on each req word, compare each rsp word
   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (reset) begin
         bases_q = QUERY_BASES_RESET;
         qlen_q  = QUERY_LENGTH_RESET;
         clear_columns();
         awaited_results.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_addr == REG_QUERY_BASES) begin
               bases_q = csr_wdata;
            end else if (csr_addr == REG_QUERY_LENGTH) begin
               qlen_q = csr_wdata[QLEN_W-1:0];
            end
         end
         // Retire the oldest prediction before adding this cycle's
         if (rsp_tvalid && rsp_tready) begin
            seen.bottom_score = rsp_tdata[14:0];
            seen.best_score   = rsp_tdata[29:15];
            seen.keep         = rsp_tdata[33:30];
            seen.strobe       = rsp_tdata[37:34];
            seen.ident        = rsp_tdata[38];
            seen.dest         = rsp_tdata[39];
            seen.group_end    = rsp_tlast;
            seen.user         = rsp_tuser;
            if (awaited_results.size() == 0) begin
               note_failure(1'b1, seen, seen);
            end else begin
               want = awaited_results.pop_front();
               if (seen !== want) note_failure(1'b0, want, seen);
               matched++;
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(score_column(req_tdata, req_tlast, req_tuser));
         end
      end
      fail_count    <= errors;
      checked_count <= matched;
      open_count    <= awaited_results.size();
   end

endmodule

FILE: test/testbench.sv
// Testbench top for the stripe scorer: clock, reset, stimulus, register settings and verdict.
module testbench
   import lass_pkg::*;
();

   localparam int ROWS          = ROWS_DEFAULT;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = ROWS + 4;
   localparam int PHASE_ITEMS   = 65;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_wr_en  = 1'b0;
   logic        csr_addr   = REG_QUERY_BASES;
   logic [31:0] csr_wdata  = '0;

   int fail_count;
   int open_count;
   int checked_count;
   int send_idle_pct  = 9;
   int recv_idle_pct  = 81;
   int columns_sent   = 0;
   int settings_used  = 1;
   int quiet_cycles   = 0;

   local_alignment_stripe_scorer #(.ROWS(ROWS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   stripe_scorer_checker #(.ROWS(ROWS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .csr_wr_en     (csr_wr_en),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .open_count    (open_count),
      .checked_count (checked_count)
   );

   always #1 clock = ~clock;

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one column word, with a random gap first, and hold it until taken
   task automatic send_column(input logic [15:0] sym, input logic [15:0] top,
                              input logic last, input logic [3:0] keep,
                              input logic [3:0] strobe, input logic user,
                              input logic ident, input logic dest);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, dest, ident, strobe, keep, top, sym};
      req_tlast  <= last;
      req_tuser  <= user;
      do @(posedge clock); while (!req_tready);
      columns_sent++;
   endtask

   // Send one run of random columns, closed by a final word
   task automatic send_random_run(input int length);
      logic [15:0] sym;
      logic [15:0] top;
      int          pick;
      for (int i = 0; i < length; i++) begin
         pick = $urandom_range(99);
         if (pick < 85) sym = 16'($urandom_range(3));
         else if (pick < 93) sym = 16'($urandom_range(15, 4));
         else sym = 16'($urandom_range(65535));
         pick = $urandom_range(99);
         if (pick < 70) top = 16'($urandom_range(24));
         else if (pick < 80) top = -16'($urandom_range(8));
         else if (pick < 85) top = 16'h7FFF;
         else if (pick < 90) top = 16'h8000;
         else top = 16'($urandom_range(65535));
         send_column(sym, top, i == length - 1, 4'($urandom_range(15)),
                     4'($urandom_range(15)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endtask

   // Lower valid, wait for every awaited result, then let the chain settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both query registers while the block is idle
   task automatic set_query(input logic [31:0] bases, input logic [4:0] qlen);
      csr_wr_en <= 1'b1;
      csr_addr  <= REG_QUERY_BASES;
      csr_wdata <= bases;
      @(posedge clock);
      csr_addr  <= REG_QUERY_LENGTH;
      csr_wdata <= {27'd0, qlen};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      logic [31:0] bases;
      logic [4:0]  qlen;
      int          phase_start;
      int          len;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed columns on the reset settings: all-A query, full length
      send_column(16'd0, 16'd0, 1'b0, 4'hF, 4'h0, 1'b1, 1'b0, 1'b1);
      send_column(16'd1, 16'd5, 1'b0, 4'h0, 4'hF, 1'b0, 1'b1, 1'b0);
      send_column(16'd2, 16'h7FFF, 1'b0, 4'hA, 4'h5, 1'b1, 1'b1, 1'b1);
      // diagonal term runs past the ceiling
      send_column(16'd0, 16'h7FFF, 1'b0, 4'h5, 4'hA, 1'b0, 1'b0, 1'b0);
      send_column(16'd3, 16'h8000, 1'b0, 4'hF, 4'hF, 1'b1, 1'b0, 1'b0);
      // no base: column store holds
      send_column(16'd4, 16'd10, 1'b0, 4'h0, 4'h0, 1'b0, 1'b1, 1'b1);
      send_column(16'hFFFF, 16'd3, 1'b0, 4'h3, 4'hC, 1'b1, 1'b0, 1'b1);
      send_column(16'd0, 16'hFFFF, 1'b0, 4'hC, 4'h3, 1'b0, 1'b1, 1'b0);
      // long matching run across a group boundary, then a final word
      for (int i = 0; i < 14; i++) begin
         send_column(16'd0, 16'(i), i == 13, 4'(i), 4'(15 - i), i[0], i[1], i[2]);
      end
      // single-word run
      send_column(16'd2, 16'd1, 1'b1, 4'hF, 4'hF, 1'b1, 1'b1, 1'b1);

      // Random runs under a sequence of query settings
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin bases = 32'hFFFF_FFFF; qlen = 5'd16; end
            1: begin bases = $urandom;      qlen = 5'd0;  end
            2: begin bases = $urandom;      qlen = 5'd1;  end
            3: begin bases = 32'h0;         qlen = 5'd31; end
            4: begin bases = $urandom;      qlen = 5'd17; end
            5: begin bases = $urandom;      qlen = 5'($urandom_range(16)); end
            default: begin bases = 32'h1B1B_E4E4; qlen = 5'd8; end
         endcase
         // swap idling between sides, then run without idling
         if (phase == 2) begin
            send_idle_pct = 81;
            recv_idle_pct = 9;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain();
         set_query(bases, qlen);
         phase_start = columns_sent;
         while (columns_sent - phase_start < PHASE_ITEMS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(80, 40) : $urandom_range(40, 1);
            send_random_run(len);
         end
      end
      drain();

      $display("testbench: %0d columns sent, %0d results checked, %0d query settings",
               columns_sent, checked_count, settings_used);
      $display("testbench: idling on either side and none, lengths 0 to 31, %0d mismatches",
               fail_count);
      if (fail_count == 0 && open_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lass_pkg.sv
rtl/lass_cell.sv
rtl/lass_out.sv
rtl/local_alignment_stripe_scorer.sv
test/stripe_scorer_checker.sv
test/testbench.sv
